@@ rtl/sentinel_value_table_defines.svh @@
// Assertion macros used by the checker file of the sentinel value table.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SENTINEL_VALUE_TABLE_DEFINES_SVH
`define SENTINEL_VALUE_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVT_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sentinel_value_table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SVT_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sentinel_value_table: next-cycle check failed");

`endif

@@ rtl/svt_pkg.sv @@
// ----------------------------------------------------------------------------
// svt_pkg
// Types and constants shared by the sentinel value table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package svt_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int CFG_W   = 7;
  localparam int NW      = (CW > CFG_W) ? CW : CFG_W;
  localparam int VAL_W   = 32;
  localparam int OP_W    = 2;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int QDEPTH  = 2;
  localparam int QAW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW     = $clog2(QDEPTH + 1);

  localparam logic [VAL_W-1:0] EMPTY_MARK    = 32'hFFFF_FF9D;
  localparam logic [CFG_W-1:0] ENTRIES_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
  } svt_in_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] match_count;
    logic [IDX_W-1:0] slot_index;
    logic             table_full;
  } svt_out_t;

  // Classified command handed from the front end to the scan engine.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] key;
    logic [CW-1:0]    n;
  } svt_cmd_t;

endpackage

`default_nettype wire

@@ rtl/svt_ram.sv @@
// ----------------------------------------------------------------------------
// svt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/svt_queue.sv @@
// ----------------------------------------------------------------------------
// svt_queue
// Short command queue between the front end and the scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_queue
  import svt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire svt_cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output svt_cmd_t      head_cmd,
  output logic          not_empty
);

  svt_cmd_t           slot_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]     cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == QCW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/svt_front.sv @@
// ----------------------------------------------------------------------------
// svt_front
// Accepts input items, clamps the slot count and classifies the operation.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_front
  import svt_pkg::*;
(
  input  wire logic             in_valid,
  input  wire svt_in_t          in_data,
  output logic                  in_stall,
  input  wire logic [CFG_W-1:0] entries_in_use,
  output logic                  push,
  output svt_cmd_t              push_cmd,
  input  wire logic             q_full
);

  logic [NW-1:0] req_n;
  logic [CW-1:0] act_n;
  logic          known_op;

  assign req_n    = NW'(entries_in_use);
  assign act_n    = (req_n > NW'(DEPTH)) ? CW'(DEPTH) : CW'(req_n);
  assign known_op = (in_data.op == OP_INSERT) || (in_data.op == OP_SEARCH) ||
                    (in_data.op == OP_DELETE);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // An unknown operation scans no slots, so it finishes with all-zero results.
  always_comb begin
    push_cmd.op  = in_data.op;
    push_cmd.key = in_data.value;
    push_cmd.n   = known_op ? act_n : '0;
  end

endmodule

`default_nettype wire

@@ rtl/svt_back.sv @@
// ----------------------------------------------------------------------------
// svt_back
// Scan engine: walks the slots in use one per cycle and owns the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_back
  import svt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_not_empty,
  input  wire svt_cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  output svt_out_t      out_data,
  input  wire logic     out_stall
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  svt_cmd_t         cmd_r, cmd_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  svt_out_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  svt_out_t         out_r, out_nxt;

  logic             ram_we;
  logic [VAL_W-1:0] rdata;
  logic [VAL_W-1:0] slot_val;
  logic [VAL_W-1:0] cmp_key;
  logic             is_ins, is_del, issue, match, out_free;

  svt_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pend_idx_r),
    .wdata(cmd_r.key),
    .raddr(idx_r[AW-1:0]),
    .rdata(rdata)
  );

  assign is_ins   = (cmd_r.op == OP_INSERT);
  assign is_del   = (cmd_r.op == OP_DELETE);
  assign issue    = (idx_r < cmd_r.n);
  // A slot that was never written, or was deleted, reads as the empty mark.
  assign slot_val = valid_r[pend_idx_r] ? rdata : EMPTY_MARK;
  assign cmp_key  = is_ins ? EMPTY_MARK : cmd_r.key;
  assign match    = pend_r && (slot_val == cmp_key);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match && is_ins) begin
          // First empty slot: store the value and stop; the read issued
          // this cycle is dropped.
          ram_we                = 1'b1;
          valid_nxt[pend_idx_r] = 1'b1;
          res_nxt.found         = 1'b1;
          res_nxt.match_count   = '0;
          res_nxt.slot_index    = IDX_W'(pend_idx_r);
          res_nxt.table_full    = 1'b0;
          pend_nxt              = 1'b0;
          state_nxt             = ST_DONE;
        end else begin
          if (match) begin
            cnt_nxt = cnt_r + 1'b1;
            if (is_del) begin
              valid_nxt[pend_idx_r] = 1'b0;
            end
          end
          if (issue) begin
            idx_nxt      = idx_r + 1'b1;
            pend_nxt     = 1'b1;
            pend_idx_nxt = idx_r[AW-1:0];
          end else begin
            pend_nxt = 1'b0;
          end
          if (!pend_r && !issue) begin
            res_nxt.found       = !is_ins && (cnt_r != '0);
            res_nxt.match_count = is_ins ? '0 : CNT_W'(cnt_r);
            res_nxt.slot_index  = '0;
            res_nxt.table_full  = is_ins;
            state_nxt           = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ rtl/sentinel_value_table.sv @@
// ----------------------------------------------------------------------------
// sentinel_value_table
// Table of signed 32-bit values with insert, search and delete-all-matches.
//
// Input channel in_valid/in_stall/in_data carries one item: op and value.
// Result channel out_valid/out_stall/out_data returns exactly one item per
// input item, in order. cfg_we/cfg_wdata set the number of slots in use;
// write it only while no item is in flight.
// An item is scanned over the slots in use, one slot per cycle, through the
// slot RAM's single read port, and an insert stops early at the first empty
// slot. Items are processed one at a time. A two-entry command queue lets the
// input accept items while a scan runs, and the result register lets the
// next scan start while an earlier result waits under out_stall.
// Reset marks every slot empty at once through per-slot valid flags and sets
// the slot count to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sentinel_value_table
  import svt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire svt_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output svt_out_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] entries_in_use_r, entries_in_use_nxt;
  logic             push, q_full, q_pop, q_not_empty;
  svt_cmd_t         push_cmd, q_cmd;

  assign entries_in_use_nxt = cfg_we ? cfg_wdata : entries_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= ENTRIES_RESET;
    end else begin
      entries_in_use_r <= entries_in_use_nxt;
    end
  end

  svt_front u_front (
    .in_valid      (in_valid),
    .in_data       (in_data),
    .in_stall      (in_stall),
    .entries_in_use(entries_in_use_r),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  svt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (q_cmd),
    .not_empty(q_not_empty)
  );

  svt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule

`default_nettype wire

@@ rtl/svt_checker.sv @@
// ----------------------------------------------------------------------------
// svt_checker
// Port-level checks on the result channel of the sentinel value table.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sentinel_value_table_defines.svh"

module svt_checker
  import svt_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire svt_out_t out_data
);

  // A stalled result item stays on the port unchanged.
  `SVT_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // A full table reports nothing else.
  `SVT_CHECK_NOW(a_full_clean, out_valid && out_data.table_full, !out_data.found && (out_data.match_count == '0) && (out_data.slot_index == '0))

  // Matches always imply found, and no match means no count.
  `SVT_CHECK_NOW(a_count_found, out_valid && !out_data.found, out_data.match_count == '0)

  // Only a successful insert names a slot, and an insert counts no matches.
  `SVT_CHECK_NOW(a_slot_insert, out_valid && (out_data.slot_index != '0), out_data.found && !out_data.table_full && (out_data.match_count == '0))

endmodule

bind sentinel_value_table svt_checker u_svt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

@@ tb/sentinel_value_table_checker.sv @@
// ----------------------------------------------------------------------------
// sentinel_value_table_checker
// Watches both channels and the slot-count port of the table. It keeps its own
// copy of the slots, works out the result of every accepted item, and compares
// each returned result field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module sentinel_value_table_checker
  import svt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  svt_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  svt_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending,
  output int               results_checked,
  output int               full_inserts
);

  localparam int REPORT_LIMIT = 100;

  logic [VAL_W-1:0] slot_mem [DEPTH];
  logic [CFG_W-1:0] slots_in_use;
  svt_out_t         owed_results [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    full_inserts    = 0;
  end

  // Applies one item to the local slot copy and returns the result it owes.
  function automatic svt_out_t apply_table_op(input svt_in_t item);
    svt_out_t   res;
    int         active;
    int         k;
    logic [6:0] hits;
    res    = '0;
    hits   = '0;
    active = (slots_in_use > DEPTH) ? DEPTH : int'(slots_in_use);
    case (item.op)
      OP_INSERT: begin
        res.table_full = 1'b1;
        for (k = 0; k < active; k++) begin
          if (slot_mem[k] == EMPTY_MARK) begin
            slot_mem[k]    = item.value;
            res.slot_index = IDX_W'(k);
            res.found      = 1'b1;
            res.table_full = 1'b0;
            break;
          end
        end
      end
      OP_SEARCH, OP_DELETE: begin
        for (k = 0; k < active; k++) begin
          if (slot_mem[k] == item.value) begin
            hits++;
            if (item.op == OP_DELETE) slot_mem[k] = EMPTY_MARK;
          end
        end
        res.match_count = hits;
        res.found       = (hits != 0);
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    svt_out_t want;
    if (!rst_n) begin
      foreach (slot_mem[k]) slot_mem[k] = EMPTY_MARK;
      slots_in_use = ENTRIES_RESET;
      owed_results.delete();
    end else begin
      // Retire before predicting so a result is never matched to its own item.
      if (out_valid && !out_stall) begin
        results_checked++;
        if (owed_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result with none owed: expected nothing, got found=%0d count=%0d slot=%0d full=%0d",
                     $time, out_data.found, out_data.match_count, out_data.slot_index,
                     out_data.table_full);
        end else begin
          want = owed_results.pop_front();
          if (want.table_full) full_inserts++;
          if (out_data.found !== want.found || out_data.match_count !== want.match_count ||
              out_data.slot_index !== want.slot_index ||
              out_data.table_full !== want.table_full) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: result mismatch: expected found=%0d count=%0d slot=%0d full=%0d, got found=%0d count=%0d slot=%0d full=%0d",
                       $time, want.found, want.match_count, want.slot_index, want.table_full,
                       out_data.found, out_data.match_count, out_data.slot_index,
                       out_data.table_full);
          end
        end
      end
      if (cfg_we) slots_in_use = cfg_wdata;
      if (in_valid && !in_stall) owed_results.push_back(apply_table_op(in_data));
    end
    pending = owed_results.size();
  end

endmodule

@@ tb/sentinel_value_table_tb.sv @@
// ----------------------------------------------------------------------------
// sentinel_value_table_tb
// Drives the sentinel value table with a short directed run over the field
// extremes and corner cases, then with random phases at different slot counts
// and insert/delete mixes, under bursty input and random result back-pressure.
// ----------------------------------------------------------------------------
module sentinel_value_table_tb;
  import svt_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES    = 600;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 150;
  localparam int DRAIN_CYCLES   = DEPTH + 16;
  localparam int POOL_SIZE      = 6;

  localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  svt_in_t          in_data;
  logic             out_valid;
  logic             out_stall;
  svt_out_t         out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int results_checked;
  int full_inserts;

  int   burst_left         = 0;
  int   items_sent         = 0;
  int   cfg_writes         = 0;
  int   input_stall_cycles = 0;
  logic hold_off_req       = 1'b0;

  logic [VAL_W-1:0] key_pool [POOL_SIZE];

  sentinel_value_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sentinel_value_table_checker table_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .full_inserts    (full_inserts)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
    svt_in_t item;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    item.op    = op;
    item.value = val;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Slot count changes only once every owed result has come back.
  task automatic write_slot_count(input logic [CFG_W-1:0] count);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (r < 75) return EMPTY_MARK;
    else if (r < 80) return r[0] ? VAL_MAX : VAL_MIN;
    else return $urandom();
  endfunction

  task automatic run_random_items(input int insert_pct, input int n_items);
    int              r;
    logic [OP_W-1:0] op;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_UNUSED;
      else if (r < 3 + insert_pct) op = OP_INSERT;
      else if (r[0]) op = OP_SEARCH;
      else op = OP_DELETE;
      issue_op(op, pick_value());
    end
  endtask

  // Result side: the stall pattern switches at random among four modes, and one
  // long hold-off lets the block fill up and push back on its input.
  initial begin : result_sink
    int mode;
    int span;
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        if (hold_off_req && !hold_done) begin
          hold_done = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] count;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed run, starting from the reset slot count of 64.
    issue_op(OP_INSERT, VAL_MAX);
    issue_op(OP_INSERT, VAL_MIN);
    issue_op(OP_INSERT, EMPTY_MARK);   // lands in an empty slot and leaves it empty
    issue_op(OP_INSERT, 32'd0);
    issue_op(OP_INSERT, VAL_MAX);
    issue_op(OP_SEARCH, VAL_MAX);
    issue_op(OP_SEARCH, EMPTY_MARK);   // the empty marker counts empty slots
    issue_op(OP_SEARCH, 32'd12345);
    issue_op(OP_UNUSED, 32'hFFFF_FFFF);
    issue_op(OP_DELETE, VAL_MAX);
    issue_op(OP_DELETE, 32'd5);

    // Shrink to two slots: slot 2 still holds zero but is out of reach.
    write_slot_count(7'd2);
    issue_op(OP_INSERT, 32'd7);
    issue_op(OP_INSERT, 32'd8);
    issue_op(OP_SEARCH, 32'd0);

    write_slot_count(7'd0);
    issue_op(OP_INSERT, 32'd1);
    issue_op(OP_SEARCH, EMPTY_MARK);
    issue_op(OP_DELETE, 32'd7);

    // Counts above the table size saturate; hidden slots come back into view.
    write_slot_count(7'd127);
    issue_op(OP_SEARCH, 32'd0);
    issue_op(OP_SEARCH, EMPTY_MARK);
    issue_op(OP_DELETE, EMPTY_MARK);

    write_slot_count(7'd1);
    issue_op(OP_DELETE, 32'd7);
    issue_op(OP_INSERT, 32'hFFFF_FFFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       count = 7'd64;
        1:       count = 7'd1;
        2:       count = 7'd127;
        3:       count = 7'd0;
        4:       count = 7'd64;
        5:       count = 7'd2;
        default: count = CFG_W'($urandom_range(0, 127));
      endcase
      write_slot_count(count);
      foreach (key_pool[i]) key_pool[i] = $urandom();
      // A key one bit away from the empty marker must never match empty slots.
      key_pool[0] = EMPTY_MARK ^ (32'd1 << $urandom_range(0, 31));
      if (p == 4) hold_off_req = 1'b1;
      case (p % 3)
        0:       run_random_items(70, PHASE_ITEMS);
        1:       run_random_items(45, PHASE_ITEMS);
        default: run_random_items(25, PHASE_ITEMS);
      endcase
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d items under %0d slot-count settings; %0d results checked, %0d of them full-table inserts.",
             items_sent, cfg_writes, results_checked, full_inserts);
    $display("Input was pushed back for %0d cycles, including during one %0d-cycle result hold-off.",
             input_stall_cycles, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("sentinel_value_table test passed");
    end else begin
      $display("sentinel_value_table test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timed out with %0d results still owed.", pending);
    $display("sentinel_value_table test failed");
    $finish;
  end

endmodule

@@ sentinel_value_table.f @@
+incdir+rtl
rtl/svt_pkg.sv
rtl/svt_ram.sv
rtl/svt_queue.sv
rtl/svt_front.sv
rtl/svt_back.sv
rtl/sentinel_value_table.sv
rtl/svt_checker.sv
tb/sentinel_value_table_checker.sv
tb/sentinel_value_table_tb.sv
